// ===== rtl/htfd_pkg.sv =====
package htfd_pkg;

	// Frame result status
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TEMP_CRC = 2'd1,
		ST_HUM_CRC  = 2'd2
	} status_t;

	// CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Scaling: result = offset + floor(raw * scale / 65535)
	localparam int TEMP_SCALE      = 17500;
	localparam int TEMP_OFFSET_MAG = 4500;
	localparam int HUM_SCALE       = 10000;

	localparam int PROD_W = 31;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	// One complete frame, as handed from front to back
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		status_t     status;
	} job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
		logic push;
		logic pop;
	} q_stat_t;

	// One byte through the CRC
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 65535 * 32768: x = q0 * 65536 + lo, so
	// x - q0 * 65535 = lo + q0, which stays below twice the divisor
	function automatic logic [15:0] div_ffff(input logic [PROD_W-1:0] x);
		logic [15:0] q0;
		logic [16:0] r;
		q0 = {1'b0, x[PROD_W-1:16]};
		r  = {1'b0, x[15:0]} + {1'b0, q0};
		return q0 + ((r >= 17'h0FFFF) ? 16'd1 : 16'd0);
	endfunction

endpackage

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
// Decodes six-byte humidity/temperature measurement frames, one byte per
// request on the slave side, start of frame flagged in s_tuser. Each CRC-8
// (polynomial 0x31, seed 0xFF) covers the two data bytes before it. After the
// sixth byte one request leaves on the master side with the scaled values
// (0.01 degC, 0.01 %RH) and a status: 0 ok, 1 temperature CRC bad, 2 humidity
// CRC bad; on a failure the last good values are repeated. Bytes are taken
// every cycle; the front updates the CRC in the cycle a byte arrives, and a
// finished frame passes through a two-entry queue, a multiply stage and the
// output register before its result is offered on the master side.
// The slave side stalls only while the queue is full.
module humidity_temp_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [14:0] temp_centi, [28:15] humidity_centi,
	                               // [30:29] frame_status, [31] zero
);
	import htfd_pkg::*;

	logic               accept;
	logic               push;
	logic               pop;
	job_t               push_data;
	job_t               pop_data;
	q_stat_t            q_stat;
	logic signed [14:0] temp_centi;
	logic [13:0]        humidity_centi;
	status_t            frame_status;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// Front: byte position, CRC check, raw words
	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.push        (push),
		.push_data   (push_data)
	);

	// Queue of finished frames
	htfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Back: scaling and result register
	htfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (!q_stat.empty),
		.job            (pop_data),
		.pop            (pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.temp_centi     (temp_centi),
		.humidity_centi (humidity_centi),
		.frame_status   (frame_status)
	);

	assign m_tdata = {1'b0, frame_status, humidity_centi, temp_centi};

	// Front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.push |-> !q_stat.full)
		else $error("frame queue overflow");

	// Back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop |-> !q_stat.empty)
		else $error("frame queue underflow");

	// Offered results stay within the scaled ranges
	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(temp_centi) >= -15'sd4500) && ($signed(temp_centi) <= 15'sd13000)
			&& (humidity_centi <= 14'd10000)))
		else $error("result out of range");

endmodule

// ===== rtl/htfd_front.sv =====
module htfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                push,
	output htfd_pkg::job_t      push_data
);
	import htfd_pkg::*;

	// Byte positions within a frame
	localparam logic [2:0] P_T_HI  = 3'd0;
	localparam logic [2:0] P_T_LO  = 3'd1;
	localparam logic [2:0] P_T_CRC = 3'd2;
	localparam logic [2:0] P_H_HI  = 3'd3;
	localparam logic [2:0] P_H_LO  = 3'd4;
	localparam logic [2:0] P_H_CRC = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_raw_q;
	logic [15:0] hum_raw_q;
	logic        tfail_q;

	logic [2:0]  idx;
	logic        active;
	logic        take;

	// A start mark restarts the frame; stray bytes while idle are dropped
	always_comb begin
		idx    = frame_start ? P_T_HI : pos_q;
		active = frame_start || (pos_q inside {[P_T_LO:P_H_CRC]});
		take   = accept && active;
	end

	// Frame status on the last byte
	always_comb begin
		push               = take && (idx == P_H_CRC);
		push_data.temp_raw = temp_raw_q;
		push_data.hum_raw  = hum_raw_q;
		if (tfail_q) begin
			push_data.status = ST_TEMP_CRC;
		end else if (rx_byte != crc_q) begin
			push_data.status = ST_HUM_CRC;
		end else begin
			push_data.status = ST_OK;
		end
	end

	// Byte position, CRC and raw words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= P_T_HI;
			crc_q      <= CRC_INIT;
			temp_raw_q <= '0;
			hum_raw_q  <= '0;
			tfail_q    <= 1'b0;
		end else if (take) begin
			pos_q <= (idx == P_H_CRC) ? P_T_HI : idx + 3'd1;
			case (idx)
				P_T_HI: begin
					crc_q      <= crc8_byte(CRC_INIT, rx_byte);
					temp_raw_q <= {rx_byte, 8'h00};
				end
				P_T_LO: begin
					crc_q            <= crc8_byte(crc_q, rx_byte);
					temp_raw_q[7:0]  <= rx_byte;
				end
				P_T_CRC: begin
					tfail_q <= (rx_byte != crc_q);
					crc_q   <= CRC_INIT;
				end
				P_H_HI: begin
					crc_q     <= crc8_byte(CRC_INIT, rx_byte);
					hum_raw_q <= {rx_byte, 8'h00};
				end
				P_H_LO: begin
					crc_q           <= crc8_byte(crc_q, rx_byte);
					hum_raw_q[7:0]  <= rx_byte;
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

// ===== rtl/htfd_queue.sv =====
module htfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  htfd_pkg::job_t      push_data,
	input  logic                pop,
	output htfd_pkg::job_t      pop_data,
	output htfd_pkg::q_stat_t   stat
);
	import htfd_pkg::*;

	job_t                mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q;
	logic [QUEUE_AW-1:0] rptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	always_comb begin
		stat.full  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
		stat.empty = (cnt_q == '0);
		stat.push  = push;
		stat.pop   = pop;
		pop_data   = mem[rptr_q];
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/htfd_back.sv =====
module htfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	input  htfd_pkg::job_t      job,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic signed [14:0]  temp_centi,
	output logic [13:0]         humidity_centi,
	output htfd_pkg::status_t   frame_status
);
	import htfd_pkg::*;

	logic                vld_s1;
	logic [PROD_W-1:0]   tprod_s1;
	logic [PROD_W-1:0]   hprod_s1;
	status_t             status_s1;

	logic                out_vld_q;
	logic signed [14:0]  last_temp_q;
	logic [13:0]         last_hum_q;
	status_t             status_q;

	logic                out_free;
	logic                s1_ready;
	logic [15:0]         tq;
	logic [15:0]         hq;
	logic [15:0]         tsum;

	// Handshake through the two stages
	always_comb begin
		out_free = !out_vld_q || m_tready;
		s1_ready = !vld_s1 || out_free;
		pop      = avail && s1_ready;
	end

	// Stage 1: constant multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_ready) begin
			vld_s1 <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tprod_s1  <= PROD_W'({15'd0, job.temp_raw} * PROD_W'(TEMP_SCALE));
			hprod_s1  <= PROD_W'({15'd0, job.hum_raw} * PROD_W'(HUM_SCALE));
			status_s1 <= job.status;
		end
	end

	// Stage 2: divide by 65535, apply offset
	always_comb begin
		tq   = div_ffff(tprod_s1);
		hq   = div_ffff(hprod_s1);
		tsum = tq - 16'(TEMP_OFFSET_MAG);
	end

	// Output register; the last good values are kept on a CRC failure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			last_temp_q <= '0;
			last_hum_q  <= '0;
			status_q    <= ST_OK;
		end else if (out_free) begin
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				status_q <= status_s1;
				if (status_s1 == ST_OK) begin
					last_temp_q <= $signed(tsum[14:0]);
					last_hum_q  <= hq[13:0];
				end
			end
		end
	end

	assign m_tvalid       = out_vld_q;
	assign temp_centi     = last_temp_q;
	assign humidity_centi = last_hum_q;
	assign frame_status   = status_q;

endmodule
